@@ rtl/pqr_pkg.sv @@
// Shared types, constants and codes for the process id queue with remove.
package pqr_pkg;

	localparam int DEPTH   = 16;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int ID_W    = 16;
	localparam int COUNT_W = 5;

	typedef logic [1:0] action_t;
	localparam action_t ACT_PUSH   = 2'd0;
	localparam action_t ACT_POP    = 2'd1;
	localparam action_t ACT_REMOVE = 2'd2;
	localparam action_t ACT_NONE   = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NOT_FOUND = 2'd1;
	localparam status_t ST_FULL      = 2'd2;

	typedef struct packed {
		action_t           action;
		logic [ID_W-1:0]   proc_id;
	} in_req_t;

	typedef struct packed {
		status_t            status;
		logic [ID_W-1:0]    id_out;
		logic [COUNT_W-1:0] count;
	} out_rsp_t;

	typedef enum logic [1:0] {
		RD_IDX  = 2'd0,
		RD_IDX1 = 2'd1,
		RD_IDX2 = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    accept;
		logic    push_wr;
		logic    shift_wr;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    idx_inc;
		logic    head_inc;
		logic    occ_inc;
		logic    occ_dec;
		logic    res_set;
		status_t res_status;
		logic    res_from_rd;
		logic    out_load;
	} ctrl_t;

	typedef struct packed {
		action_t action;
		logic    full;
		logic    empty;
		logic    match;
		logic    idx1_lt;
		logic    idx2_lt;
		logic    out_busy;
	} stat_t;

endpackage

@@ rtl/pqr_ctrl.sv @@
// Sequencer for push, pop and remove-by-id with compaction of the tail.
module pqr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pqr_pkg::stat_t stat,
	output pqr_pkg::ctrl_t ctrl
);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DECIDE   = 6'b000010,
		S_POP_WAIT = 6'b000100,
		S_CMP      = 6'b001000,
		S_SHIFT    = 6'b010000,
		S_DONE     = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		ctrl.rd_sel     = pqr_pkg::RD_IDX;
		ctrl.res_status = pqr_pkg::ST_NOT_FOUND;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.accept = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				ctrl.res_set = 1'b1;
				state_d      = S_DONE;
				priority if (stat.action == pqr_pkg::ACT_PUSH) begin
					if (stat.full) begin
						ctrl.res_status = pqr_pkg::ST_FULL;
					end else begin
						ctrl.push_wr    = 1'b1;
						ctrl.occ_inc    = 1'b1;
						ctrl.res_status = pqr_pkg::ST_OK;
					end
				end else if (stat.action == pqr_pkg::ACT_POP && !stat.empty) begin
					ctrl.res_set = 1'b0;
					ctrl.rd_en   = 1'b1;
					state_d      = S_POP_WAIT;
				end else if (stat.action == pqr_pkg::ACT_REMOVE && !stat.empty) begin
					ctrl.res_set = 1'b0;
					ctrl.rd_en   = 1'b1;
					state_d      = S_CMP;
				end else begin
					ctrl.res_status = pqr_pkg::ST_NOT_FOUND;
				end
			end
			S_POP_WAIT: begin
				ctrl.res_set     = 1'b1;
				ctrl.res_status  = pqr_pkg::ST_OK;
				ctrl.res_from_rd = 1'b1;
				ctrl.head_inc    = 1'b1;
				ctrl.occ_dec     = 1'b1;
				state_d          = S_DONE;
			end
			S_CMP: begin
				if (stat.match) begin
					ctrl.res_set     = 1'b1;
					ctrl.res_status  = pqr_pkg::ST_OK;
					ctrl.res_from_rd = 1'b1;
					if (stat.idx1_lt) begin
						ctrl.rd_en  = 1'b1;
						ctrl.rd_sel = pqr_pkg::RD_IDX1;
						state_d     = S_SHIFT;
					end else begin
						ctrl.occ_dec = 1'b1;
						state_d      = S_DONE;
					end
				end else if (stat.idx1_lt) begin
					ctrl.idx_inc = 1'b1;
					ctrl.rd_en   = 1'b1;
					ctrl.rd_sel  = pqr_pkg::RD_IDX1;
				end else begin
					ctrl.res_set    = 1'b1;
					ctrl.res_status = pqr_pkg::ST_NOT_FOUND;
					state_d         = S_DONE;
				end
			end
			S_SHIFT: begin
				ctrl.shift_wr = 1'b1;
				ctrl.idx_inc  = 1'b1;
				if (stat.idx2_lt) begin
					ctrl.rd_en  = 1'b1;
					ctrl.rd_sel = pqr_pkg::RD_IDX2;
				end else begin
					ctrl.occ_dec = 1'b1;
					state_d      = S_DONE;
				end
			end
			S_DONE: begin
				if (!stat.out_busy) begin
					ctrl.out_load = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/pqr_dp.sv @@
// Circular entry store, pointers, compare and output register.
module pqr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  pqr_pkg::in_req_t  in_data,
	input  pqr_pkg::ctrl_t    ctrl,
	output pqr_pkg::stat_t    stat,
	output logic              out_valid,
	input  logic              out_ready,
	output pqr_pkg::out_rsp_t out_data
);

	logic [pqr_pkg::ID_W-1:0] mem [pqr_pkg::DEPTH];

	pqr_pkg::action_t          act_q;
	logic [pqr_pkg::ID_W-1:0]  id_q;
	logic [pqr_pkg::AW-1:0]    head_q;
	logic [pqr_pkg::CW-1:0]    occ_q;
	logic [pqr_pkg::CW-1:0]    idx_q;
	logic [pqr_pkg::ID_W-1:0]  rdata_q;
	pqr_pkg::status_t          res_status_q;
	logic [pqr_pkg::ID_W-1:0]  res_id_q;
	logic                      out_valid_q;
	pqr_pkg::out_rsp_t         out_q;

	logic [pqr_pkg::CW:0]      idx1, idx2;
	logic [pqr_pkg::AW-1:0]    rd_addr, wr_addr;
	logic [pqr_pkg::CW-1:0]    rd_off;
	logic [pqr_pkg::ID_W-1:0]  wr_data;

	function automatic logic [pqr_pkg::AW-1:0] slot(
		input logic [pqr_pkg::AW-1:0] base,
		input logic [pqr_pkg::CW-1:0] off
	);
		logic [pqr_pkg::CW:0] s;
		s = (pqr_pkg::CW+1)'(base) + (pqr_pkg::CW+1)'(off);
		if (s >= (pqr_pkg::CW+1)'(pqr_pkg::DEPTH)) begin
			s = s - (pqr_pkg::CW+1)'(pqr_pkg::DEPTH);
		end
		return s[pqr_pkg::AW-1:0];
	endfunction

	assign idx1 = (pqr_pkg::CW+1)'(idx_q) + (pqr_pkg::CW+1)'(1);
	assign idx2 = (pqr_pkg::CW+1)'(idx_q) + (pqr_pkg::CW+1)'(2);

	always_comb begin
		unique case (ctrl.rd_sel)
			pqr_pkg::RD_IDX:  rd_off = idx_q;
			pqr_pkg::RD_IDX1: rd_off = idx1[pqr_pkg::CW-1:0];
			pqr_pkg::RD_IDX2: rd_off = idx2[pqr_pkg::CW-1:0];
			default:          rd_off = idx_q;
		endcase
	end

	assign rd_addr = slot(head_q, rd_off);
	assign wr_addr = ctrl.push_wr ? slot(head_q, occ_q) : slot(head_q, idx_q);
	assign wr_data = ctrl.push_wr ? id_q : rdata_q;

	always_ff @(posedge clk) begin
		if (ctrl.push_wr || ctrl.shift_wr) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			act_q <= in_data.action;
			id_q  <= in_data.proc_id;
		end
		if (ctrl.res_set) begin
			res_status_q <= ctrl.res_status;
			res_id_q     <= ctrl.res_from_rd ? rdata_q : '0;
		end
		if (ctrl.out_load) begin
			out_q.status <= res_status_q;
			out_q.id_out <= res_id_q;
			out_q.count  <= pqr_pkg::COUNT_W'(occ_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			occ_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.accept) begin
				idx_q <= '0;
			end else if (ctrl.idx_inc) begin
				idx_q <= idx1[pqr_pkg::CW-1:0];
			end
			if (ctrl.head_inc) begin
				head_q <= slot(head_q, pqr_pkg::CW'(1));
			end
			if (ctrl.occ_inc) begin
				occ_q <= occ_q + pqr_pkg::CW'(1);
			end else if (ctrl.occ_dec) begin
				occ_q <= occ_q - pqr_pkg::CW'(1);
			end
			if (ctrl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.action   = act_q;
	assign stat.full     = (occ_q >= pqr_pkg::CW'(pqr_pkg::DEPTH));
	assign stat.empty    = (occ_q == '0);
	assign stat.match    = (rdata_q == id_q);
	assign stat.idx1_lt  = (idx1 < (pqr_pkg::CW+1)'(occ_q));
	assign stat.idx2_lt  = (idx2 < (pqr_pkg::CW+1)'(occ_q));
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/process_queue_with_remove.sv @@
// Top level of the ordered process id queue with push, pop and remove-by-id.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+-------------------------------------
//  in      | in_valid  | in_ready  | in_data  {action, proc_id}
//  out     | out_valid | out_ready | out_data {status, id_out, count}
//
// One request at a time; the entry store has one read and one write port.
// Push, the unused code and pop or remove on an empty queue complete from the decide state;
// pop reads the head entry once; remove walks the held entries (each is compared or shifted once)
// through the single read port.
// Reset clears the pointers, the count and the output valid; entries hold garbage.
// A result waiting in the output register stalls only the completion of the next request.
module process_queue_with_remove (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pqr_pkg::in_req_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pqr_pkg::out_rsp_t out_data
);

	pqr_pkg::ctrl_t ctrl;
	pqr_pkg::stat_t stat;

	pqr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	pqr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctrl      (ctrl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ tb/tb_process_queue_with_remove.sv @@
// Self-checking testbench for the process id queue with push, pop and remove-by-id.
module tb_process_queue_with_remove;
	import pqr_pkg::*;

	localparam int LIMIT     = 1000000;
	localparam int TAIL_WAIT = 2 * DEPTH + 8;

	class queue_ledger;
		logic [ID_W-1:0] ids_held[$];
		out_rsp_t        rsp_due[$];
		int              errors;

		function void flag(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%s", msg);
			end
		endfunction

		function out_rsp_t apply_action(in_req_t req);
			out_rsp_t r;
			bit       found;
			r.status = ST_NOT_FOUND;
			r.id_out = '0;
			found    = 1'b0;
			case (req.action)
				ACT_PUSH: begin
					if (ids_held.size() >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						ids_held.push_back(req.proc_id);
						r.status = ST_OK;
					end
				end
				ACT_POP: begin
					if (ids_held.size() > 0) begin
						r.id_out = ids_held.pop_front();
						r.status = ST_OK;
					end
				end
				ACT_REMOVE: begin
					for (int i = 0; i < ids_held.size() && !found; i++) begin
						if (ids_held[i] == req.proc_id) begin
							r.id_out = ids_held[i];
							ids_held.delete(i);
							r.status = ST_OK;
							found    = 1'b1;
						end
					end
				end
				default: ;
			endcase
			r.count = COUNT_W'(ids_held.size());
			return r;
		endfunction

		function void note_request(in_req_t req);
			rsp_due.push_back(apply_action(req));
		endfunction

		function void check_response(out_rsp_t got);
			out_rsp_t exp;
			if (rsp_due.size() == 0) begin
				flag($sformatf("unexpected response status=%0d id=%h count=%0d",
					got.status, got.id_out, got.count));
			end else begin
				exp = rsp_due.pop_front();
				if (got.status !== exp.status || got.id_out !== exp.id_out
						|| got.count !== exp.count) begin
					flag($sformatf("mismatch: exp status=%0d id=%h count=%0d, got status=%0d id=%h count=%0d",
						exp.status, exp.id_out, exp.count, got.status, got.id_out, got.count));
				end
			end
		endfunction

		function int pending();
			return rsp_due.size();
		endfunction

		function logic [ID_W-1:0] pick_held();
			return ids_held[$urandom_range(0, ids_held.size() - 1)];
		endfunction

		function int held_count();
			return ids_held.size();
		endfunction

		function void close_out();
			if (rsp_due.size() != 0) begin
				flag($sformatf("%0d responses never arrived", rsp_due.size()));
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	in_req_t  in_data;
	logic     out_valid;
	logic     out_ready;
	out_rsp_t out_data;

	queue_ledger ledger;
	int          cycles = 0;
	bit          rx_calm;
	bit          tx_calm;
	int          stall_left;

	process_queue_with_remove u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) begin
			return 0;
		end else if (p < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send_request(input action_t act, input logic [ID_W-1:0] pid);
		in_req_t req;
		int      gap;
		req.action  = act;
		req.proc_id = pid;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		ledger.note_request(req);
	endtask

	task automatic send_random(input int push_pct);
		int              p;
		logic [ID_W-1:0] pid;
		p = $urandom_range(0, 99);
		if ($urandom_range(0, 1) == 0) begin
			pid = ID_W'($urandom_range(0, 7));
		end else begin
			pid = ID_W'($urandom_range(0, 65535));
		end
		if (p < 3) begin
			send_request(ACT_NONE, pid);
		end else if (p < push_pct) begin
			send_request(ACT_PUSH, pid);
		end else if ($urandom_range(0, 1) == 0) begin
			send_request(ACT_POP, pid);
		end else begin
			if (ledger.held_count() > 0 && $urandom_range(0, 3) != 0) begin
				pid = ledger.pick_held();
			end
			send_request(ACT_REMOVE, pid);
		end
	endtask

	// receiver back-pressure
	initial begin
		stall_left = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (!rx_calm && $urandom_range(0, 9) < 3) begin
				stall_left = pick_gap();
			end
			out_ready <= (stall_left == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			ledger.check_response(out_data);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb_process_queue_with_remove NOT OK");
			$finish;
		end
	end

	initial begin
		ledger    = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		rx_calm   = 1'b0;
		tx_calm   = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// empty queue, unused code, extremes, duplicates, absent id
		send_request(ACT_POP, 16'h0000);
		send_request(ACT_REMOVE, 16'h0000);
		send_request(ACT_NONE, 16'hFFFF);
		send_request(ACT_PUSH, 16'hFFFF);
		send_request(ACT_PUSH, 16'h0000);
		send_request(ACT_PUSH, 16'h1234);
		send_request(ACT_PUSH, 16'h1234);
		send_request(ACT_REMOVE, 16'h1234);
		send_request(ACT_REMOVE, 16'hAAAA);
		send_request(ACT_POP, 16'h5555);
		// fill up, then push into a full queue
		for (int i = 0; i < 14; i++) begin
			send_request(ACT_PUSH, ID_W'(16'h0100 + i));
		end
		send_request(ACT_PUSH, 16'hBEEF);

		for (int blk = 0; blk < 36; blk++) begin
			int push_pct;
			push_pct = $urandom_range(15, 85);
			tx_calm  = ($urandom_range(0, 4) == 0);
			rx_calm  = ($urandom_range(0, 4) == 0);
			if (blk == 18) begin
				@(negedge clk);
				in_valid <= 1'b0;
				while (ledger.pending() != 0) @(posedge clk);
			end
			for (int k = 0; k < 40; k++) begin
				send_random(push_pct);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (ledger.pending() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		ledger.close_out();
		if (ledger.errors == 0) begin
			$display("tb_process_queue_with_remove OK");
		end else begin
			$display("tb_process_queue_with_remove NOT OK");
		end
		$finish;
	end

endmodule
